/* src/sed_pkg.sv */
// Package with the item types, byte codes and character helpers of the string escape decoder.
`default_nettype none

package sed_pkg;

    // One raw byte of a quoted token.
    typedef struct packed {
        logic [7:0] token_byte;
        logic       first_of_token;
        logic       last_of_token;
    } tok_item_t;

    // One decoded result.
    typedef struct packed {
        logic [7:0] byte_value;
        logic       byte_valid;
        logic [1:0] report;
        logic       literal_done;
        logic       last_in_run;
    } res_item_t;

    // Report codes.
    localparam logic [1:0] REP_NONE       = 2'd0;
    localparam logic [1:0] REP_UNKNOWN    = 2'd1;
    localparam logic [1:0] REP_HEX_NODIG  = 2'd2;
    localparam logic [1:0] REP_FRAMING    = 2'd3;

    // Characters that the decoder looks for.
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_E   = 8'h65;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;

    // Codes produced by the single-letter escapes.
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_ESC = 8'h1B;

    // Hex digit test and value: bit 4 set means the byte is a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (b >= CH_ZERO && b <= CH_NINE) begin
                d = b - CH_ZERO;
                hex_digit = {1'b1, d[3:0]};
            end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
                d = b - CH_LOWER_A + 8'd10;
                hex_digit = {1'b1, d[3:0]};
            end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
                d = b - CH_UPPER_A + 8'd10;
                hex_digit = {1'b1, d[3:0]};
            end else begin
                hex_digit = 5'd0;
            end
        end
    endfunction

    // Single-letter escape table: bit 8 set means the letter is known.
    function automatic logic [8:0] letter_code(input logic [7:0] b);
        begin
            unique case (b)
                CH_LOWER_N:   letter_code = {1'b1, CODE_LF};
                CH_LOWER_T:   letter_code = {1'b1, CODE_TAB};
                CH_LOWER_R:   letter_code = {1'b1, CODE_CR};
                CH_LOWER_F:   letter_code = {1'b1, CODE_FF};
                CH_LOWER_B:   letter_code = {1'b1, CODE_BS};
                CH_LOWER_A:   letter_code = {1'b1, CODE_BEL};
                CH_LOWER_V:   letter_code = {1'b1, CODE_VT};
                CH_LOWER_E:   letter_code = {1'b1, CODE_ESC};
                CH_BACKSLASH: letter_code = {1'b1, CH_BACKSLASH};
                CH_QUOTE:     letter_code = {1'b1, CH_QUOTE};
                CH_APOS:      letter_code = {1'b1, CH_APOS};
                default:      letter_code = {1'b0, b};
            endcase
        end
    endfunction

    function automatic res_item_t make_res(input logic [7:0] val, input logic valid,
                                           input logic [1:0] rep, input logic done);
        res_item_t r;
        begin
            r.byte_value   = valid ? val : 8'd0;
            r.byte_valid   = valid;
            r.report       = rep;
            r.literal_done = done;
            r.last_in_run  = 1'b0;
            make_res = r;
        end
    endfunction

endpackage

`default_nettype wire

/* src/string_escape_decoder_top.sv */
// Top level of the string escape decoder: input register, escape decode and result queue.
`default_nettype none

// Decodes the raw bytes of a quoted string token, one byte per item, into byte values,
// with escape, hex, octal and framing handling. An item is taken every cycle while
// tok_stall is low; it sits in the input register, is decoded in a single pass, and
// its results enter a two-entry result queue, which drives the result port. The result
// port delivers one result per cycle while res_stall is low, so an item that gives two
// results (a numeric escape closed by another byte, or a closing byte after a pending
// hex or octal escape) stalls the input when the queue has no room for its results;
// other items stall only when the queue is full and its head is not taken.
module string_escape_decoder_top
    import sed_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      tok_valid,
    output logic           tok_stall,
    input  wire tok_item_t tok,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res
);

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_BODY = 6'b000010,
        MODE_ESC  = 6'b000100,
        MODE_HEX0 = 6'b001000,
        MODE_HEXN = 6'b010000,
        MODE_OCT  = 6'b100000
    } mode_t;

    // Input register.
    tok_item_t in_reg;
    logic      in_vld_reg;

    // Token state.
    mode_t      mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic [1:0] ocnt_reg, ocnt_next;
    logic       rej_reg, rej_next;

    // Result queue.
    res_item_t q_reg [2];
    res_item_t q_next [2];
    logic [1:0] qcnt_reg, qcnt_next;

    // Decode outputs.
    res_item_t r0, r1;
    logic [1:0] nres;

    logic       pop;
    logic       fire;
    logic       accept;
    logic [1:0] cnt_p;
    res_item_t  qp0, qp1;

    logic [7:0] b;
    logic [4:0] hx;
    logic [8:0] lc;
    logic       is_oct;
    logic       bad;
    logic       body_emit;
    res_item_t  body_res;
    mode_t      body_mode;
    logic [7:0] oct_acc;

    assign res_valid = (qcnt_reg != 2'd0);
    assign res       = q_reg[0];
    assign pop       = res_valid && !res_stall;
    assign cnt_p     = qcnt_reg - {1'b0, pop};

    // The decode may only retire when the queue has room for every result it makes.
    assign fire      = in_vld_reg && (({1'b0, nres} + {1'b0, cnt_p}) <= 3'd2);
    assign tok_stall = in_vld_reg && !fire;
    assign accept    = tok_valid && !tok_stall;

    assign b         = in_reg.token_byte;
    assign hx        = hex_digit(b);
    assign lc        = letter_code(b);
    assign is_oct    = (b >= CH_ZERO) && (b <= CH_SEVEN);
    assign bad       = rej_reg || (b != CH_QUOTE);
    assign body_emit = (b != CH_BACKSLASH);
    assign body_res  = make_res(b, 1'b1, REP_NONE, 1'b0);
    assign body_mode = body_emit ? MODE_BODY : MODE_ESC;
    assign oct_acc   = {acc_reg[4:0], b[2:0]};

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        ocnt_next = ocnt_reg;
        rej_next  = rej_reg;
        r0        = '0;
        r1        = '0;
        nres      = 2'd0;

        if (in_reg.first_of_token) begin
            mode_next = MODE_IDLE;
            acc_next  = 8'd0;
            ocnt_next = 2'd0;
            rej_next  = 1'b0;
            if (in_reg.last_of_token) begin
                r0   = make_res(8'd0, 1'b0, REP_FRAMING, 1'b1);
                nres = 2'd1;
            end else begin
                rej_next  = (b != CH_QUOTE);
                mode_next = MODE_BODY;
            end
        end else if (mode_reg == MODE_IDLE) begin
            mode_next = MODE_IDLE;
        end else if (in_reg.last_of_token) begin
            // Closing byte: flush any pending escape, then the done result.
            mode_next = MODE_IDLE;
            acc_next  = 8'd0;
            ocnt_next = 2'd0;
            rej_next  = 1'b0;
            r0   = make_res(8'd0, 1'b0, bad ? REP_FRAMING : REP_NONE, 1'b1);
            nres = 2'd1;
            if (!rej_reg) begin
                unique case (mode_reg) inside
                    MODE_ESC:
                    begin
                        r0 = make_res(CH_QUOTE, !bad, bad ? REP_FRAMING : REP_NONE, 1'b1);
                    end
                    MODE_HEX0:
                    begin
                        r1   = r0;
                        r0   = make_res(8'd0, 1'b0, REP_HEX_NODIG, 1'b0);
                        nres = 2'd2;
                    end
                    MODE_HEXN, MODE_OCT:
                    begin
                        r1   = r0;
                        r0   = make_res(acc_reg, 1'b1, REP_NONE, 1'b0);
                        nres = 2'd2;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end else if (!rej_reg) begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    mode_next = MODE_BODY;
                    if (b == CH_LOWER_X || b == CH_UPPER_X) begin
                        mode_next = MODE_HEX0;
                        acc_next  = 8'd0;
                    end else if (lc[8]) begin
                        r0   = make_res(lc[7:0], 1'b1, REP_NONE, 1'b0);
                        nres = 2'd1;
                    end else if (is_oct) begin
                        mode_next = MODE_OCT;
                        acc_next  = {5'd0, b[2:0]};
                        ocnt_next = 2'd1;
                    end else begin
                        r0   = make_res(b, 1'b1, REP_UNKNOWN, 1'b0);
                        nres = 2'd1;
                    end
                end
                MODE_HEX0:
                begin
                    if (hx[4]) begin
                        acc_next  = {4'd0, hx[3:0]};
                        mode_next = MODE_HEXN;
                    end else begin
                        r0        = make_res(8'd0, 1'b0, REP_HEX_NODIG, 1'b0);
                        r1        = body_res;
                        nres      = body_emit ? 2'd2 : 2'd1;
                        mode_next = body_mode;
                    end
                end
                MODE_HEXN:
                begin
                    if (hx[4]) begin
                        acc_next = {acc_reg[3:0], hx[3:0]};
                    end else begin
                        r0        = make_res(acc_reg, 1'b1, REP_NONE, 1'b0);
                        r1        = body_res;
                        nres      = body_emit ? 2'd2 : 2'd1;
                        mode_next = body_mode;
                    end
                end
                MODE_OCT:
                begin
                    if (is_oct) begin
                        acc_next  = oct_acc;
                        ocnt_next = ocnt_reg + 2'd1;
                        // The third digit closes the escape at once.
                        if (ocnt_reg == 2'd2) begin
                            r0        = make_res(oct_acc, 1'b1, REP_NONE, 1'b0);
                            nres      = 2'd1;
                            ocnt_next = 2'd0;
                            mode_next = MODE_BODY;
                        end
                    end else begin
                        r0        = make_res(acc_reg, 1'b1, REP_NONE, 1'b0);
                        r1        = body_res;
                        nres      = body_emit ? 2'd2 : 2'd1;
                        ocnt_next = 2'd0;
                        mode_next = body_mode;
                    end
                end
                default:
                begin
                    r0        = body_res;
                    nres      = body_emit ? 2'd1 : 2'd0;
                    mode_next = body_mode;
                end
            endcase
        end

        if (nres == 2'd1) begin
            r0.last_in_run = 1'b1;
        end
        if (nres == 2'd2) begin
            r1.last_in_run = 1'b1;
        end
    end

    // Queue update: pop the head, then append this item's results behind what is left.
    always_comb
    begin
        qp0       = pop ? q_reg[1] : q_reg[0];
        qp1       = q_reg[1];
        q_next[0] = qp0;
        q_next[1] = qp1;
        qcnt_next = cnt_p;
        if (fire) begin
            qcnt_next = cnt_p + nres;
            case (cnt_p)
                2'd0:
                begin
                    q_next[0] = r0;
                    q_next[1] = r1;
                end
                2'd1:
                begin
                    q_next[1] = r0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
            mode_reg   <= MODE_IDLE;
            acc_reg    <= 8'd0;
            ocnt_reg   <= 2'd0;
            rej_reg    <= 1'b0;
            qcnt_reg   <= 2'd0;
        end else begin
            if (accept) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            if (fire) begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                ocnt_reg <= ocnt_next;
                rej_reg  <= rej_next;
            end
            qcnt_reg <= qcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_reg <= tok;
        end
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule

`default_nettype wire

/* src/sed_checker.sv */
// Port-level checker for the string escape decoder, bound to its top level.
`default_nettype none

module sed_checker
    import sed_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire res_item_t res
);

    // A stalled result item must hold.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result item changed while stalled");

    // The result that ends a token is the last one of its input item.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.literal_done |-> res.last_in_run)
        else $error("done result not marked last in run");

    // A result without a byte carries a zero byte value.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.byte_valid |-> res.byte_value == 8'd0)
        else $error("byte value not zero on result without byte");

    // A hex escape without digits never carries a byte nor ends the token.
    a_hex_nodig: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.report == REP_HEX_NODIG |-> !res.byte_valid && !res.literal_done)
        else $error("bad hex-without-digit result");

    // Framing faults are reported only on the done result, without a byte.
    a_framing: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.report == REP_FRAMING |-> res.literal_done && !res.byte_valid)
        else $error("framing report on a result that does not end the token");

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for string_escape_decoder_top that predicts decoded bytes and reports.
`timescale 1ns / 1ps

module tb;
    import sed_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 200;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_BODY,
        SCAN_ESC,
        SCAN_HEX0,
        SCAN_HEXN,
        SCAN_OCT
    } scan_mode_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      tok_valid = 1'b0;
    logic      tok_stall;
    tok_item_t tok = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    string_escape_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Raw token bytes waiting to be offered, and decoded results waiting to arrive.
    tok_item_t raw_bytes[$];
    res_item_t decoded_q[$];
    res_item_t run_q[$];

    // Decoder state as the predictor sees it.
    scan_mode_t scan = SCAN_IDLE;
    logic [7:0] digit_acc = 8'd0;
    logic [1:0] oct_digits = 2'd0;
    logic       rejected_tok = 1'b0;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  phase = 0;
    int  items_made = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    logic hold_on = 1'b0;

    logic [7:0] esc_letters [0:10] = '{CH_LOWER_N, CH_LOWER_T, CH_LOWER_R, CH_LOWER_F,
                                       CH_LOWER_B, CH_LOWER_A, CH_LOWER_V, CH_LOWER_E,
                                       CH_BACKSLASH, CH_QUOTE, CH_APOS};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic log_mismatch(input string field, input logic [7:0] got,
                                input logic [7:0] want);
        begin
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
            fail_count++;
        end
    endtask

    function automatic void emit(input logic [7:0] v, input logic vld, input logic [1:0] rep,
                                 input logic done);
        res_item_t r;
        begin
            r.byte_value   = vld ? v : 8'd0;
            r.byte_valid   = vld;
            r.report       = rep;
            r.literal_done = done;
            r.last_in_run  = 1'b0;
            run_q.push_back(r);
        end
    endfunction

    function automatic int hex_val(input logic [7:0] b);
        begin
            if (b >= CH_ZERO && b <= CH_NINE)
                hex_val = int'(b - CH_ZERO);
            else if (b >= CH_LOWER_A && b <= CH_LOWER_F)
                hex_val = int'(b - CH_LOWER_A) + 10;
            else if (b >= CH_UPPER_A && b <= CH_UPPER_F)
                hex_val = int'(b - CH_UPPER_A) + 10;
            else
                hex_val = -1;
        end
    endfunction

    function automatic void clear_token();
        begin
            scan = SCAN_IDLE;
            digit_acc = 8'd0;
            oct_digits = 2'd0;
            rejected_tok = 1'b0;
        end
    endfunction

    function automatic void take_body(input logic [7:0] b);
        begin
            scan = SCAN_BODY;
            if (b == CH_BACKSLASH)
                scan = SCAN_ESC;
            else
                emit(b, 1'b1, REP_NONE, 1'b0);
        end
    endfunction

    // Works out the results one accepted token byte causes and queues them.
    function automatic void decode_token_byte(input tok_item_t it);
        logic [7:0] b;
        logic       bad;
        int         h;
        res_item_t  r;
        begin
            b = it.token_byte;
            run_q.delete();
            if (it.first_of_token) begin
                clear_token();
                if (it.last_of_token) begin
                    emit(8'd0, 1'b0, REP_FRAMING, 1'b1);
                end
                else
                begin
                    rejected_tok = (b != CH_QUOTE);
                    scan = SCAN_BODY;
                end
            end
            else if (scan == SCAN_IDLE) begin
                // Stray byte between tokens: ignored.
            end
            else if (it.last_of_token) begin
                bad = rejected_tok || (b != CH_QUOTE);
                if (!rejected_tok && scan == SCAN_ESC) begin
                    // The closing quote is taken as the escaped letter.
                    emit(CH_QUOTE, !bad, bad ? REP_FRAMING : REP_NONE, 1'b1);
                end
                else
                begin
                    if (!rejected_tok && scan == SCAN_HEX0)
                        emit(8'd0, 1'b0, REP_HEX_NODIG, 1'b0);
                    else if (!rejected_tok && (scan == SCAN_HEXN || scan == SCAN_OCT))
                        emit(digit_acc, 1'b1, REP_NONE, 1'b0);
                    emit(8'd0, 1'b0, bad ? REP_FRAMING : REP_NONE, 1'b1);
                end
                clear_token();
            end
            else if (!rejected_tok) begin
                case (scan)
                    SCAN_ESC:
                    begin
                        scan = SCAN_BODY;
                        case (b) inside
                            CH_LOWER_N: emit(CODE_LF, 1'b1, REP_NONE, 1'b0);
                            CH_LOWER_T: emit(CODE_TAB, 1'b1, REP_NONE, 1'b0);
                            CH_LOWER_R: emit(CODE_CR, 1'b1, REP_NONE, 1'b0);
                            CH_LOWER_F: emit(CODE_FF, 1'b1, REP_NONE, 1'b0);
                            CH_LOWER_B: emit(CODE_BS, 1'b1, REP_NONE, 1'b0);
                            CH_LOWER_A: emit(CODE_BEL, 1'b1, REP_NONE, 1'b0);
                            CH_LOWER_V: emit(CODE_VT, 1'b1, REP_NONE, 1'b0);
                            CH_LOWER_E: emit(CODE_ESC, 1'b1, REP_NONE, 1'b0);
                            CH_BACKSLASH, CH_QUOTE, CH_APOS:
                                emit(b, 1'b1, REP_NONE, 1'b0);
                            CH_LOWER_X, CH_UPPER_X:
                            begin
                                scan = SCAN_HEX0;
                                digit_acc = 8'd0;
                            end
                            default:
                            begin
                                if (b >= CH_ZERO && b <= CH_SEVEN) begin
                                    scan = SCAN_OCT;
                                    digit_acc = b - CH_ZERO;
                                    oct_digits = 2'd1;
                                end
                                else
                                    emit(b, 1'b1, REP_UNKNOWN, 1'b0);
                            end
                        endcase
                    end
                    SCAN_HEX0:
                    begin
                        h = hex_val(b);
                        if (h >= 0) begin
                            digit_acc = 8'(h);
                            scan = SCAN_HEXN;
                        end
                        else
                        begin
                            emit(8'd0, 1'b0, REP_HEX_NODIG, 1'b0);
                            take_body(b);
                        end
                    end
                    SCAN_HEXN:
                    begin
                        h = hex_val(b);
                        if (h >= 0)
                            digit_acc = {digit_acc[3:0], 4'(h)};
                        else
                        begin
                            emit(digit_acc, 1'b1, REP_NONE, 1'b0);
                            take_body(b);
                        end
                    end
                    SCAN_OCT:
                    begin
                        if (b >= CH_ZERO && b <= CH_SEVEN) begin
                            digit_acc = (digit_acc << 3) + (b - CH_ZERO);
                            oct_digits = oct_digits + 2'd1;
                            // The third digit closes the escape at once.
                            if (oct_digits == 2'd3 || oct_digits == 2'd0) begin
                                emit(digit_acc, 1'b1, REP_NONE, 1'b0);
                                oct_digits = 2'd0;
                                scan = SCAN_BODY;
                            end
                        end
                        else
                        begin
                            emit(digit_acc, 1'b1, REP_NONE, 1'b0);
                            oct_digits = 2'd0;
                            take_body(b);
                        end
                    end
                    default:
                        take_body(b);
                endcase
            end
            if (run_q.size() > 0) begin
                r = run_q[run_q.size() - 1];
                r.last_in_run = 1'b1;
                run_q[run_q.size() - 1] = r;
                foreach (run_q[i])
                    decoded_q.push_back(run_q[i]);
            end
        end
    endfunction

    // Sender: holds a stalled item, otherwise offers the next one unless idling.
    always @(posedge clk)
    begin : drive
        tok_item_t next_item;
        logic      next_valid;
        next_item = tok;
        next_valid = tok_valid;
        if (rst_n) begin
            if (tok_valid && !tok_stall) begin
                decode_token_byte(tok);
                next_valid = 1'b0;
            end
            if (!next_valid && raw_bytes.size() > 0
                && $urandom_range(99) >= send_idle_pct) begin
                next_item = raw_bytes.pop_front();
                next_valid = 1'b1;
            end
        end
        tok <= next_item;
        tok_valid <= next_valid;
    end

    // Receiver: checks each accepted result against the oldest expectation.
    always @(posedge clk)
    begin : collect
        res_item_t want;
        if (rst_n && res_valid && !res_stall) begin
            if (decoded_q.size() == 0) begin
                log_mismatch("unexpected result", res.byte_value, 8'd0);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (res.byte_value !== want.byte_value)
                    log_mismatch("byte_value", res.byte_value, want.byte_value);
                if (res.byte_valid !== want.byte_valid)
                    log_mismatch("byte_valid", 8'(res.byte_valid), 8'(want.byte_valid));
                if (res.report !== want.report)
                    log_mismatch("report", 8'(res.report), 8'(want.report));
                if (res.literal_done !== want.literal_done)
                    log_mismatch("literal_done", 8'(res.literal_done), 8'(want.literal_done));
                if (res.last_in_run !== want.last_in_run)
                    log_mismatch("last_in_run", 8'(res.last_in_run), 8'(want.last_in_run));
            end
        end
        res_stall <= rst_n && (hold_on || ($urandom_range(99) < recv_idle_pct));
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** string_escape_decoder_top: FAILED **");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering, so the block backs up.
    initial
    begin : hold_off
        wait (phase == 3);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    task automatic put_byte(input logic [7:0] b, input logic first, input logic last,
                            input logic counted);
        tok_item_t t;
        begin
            t.token_byte = b;
            t.first_of_token = first;
            t.last_of_token = last;
            raw_bytes.push_back(t);
            if (counted)
                items_made++;
        end
    endtask

    task automatic push_piece();
        int r;
        begin
            case ($urandom_range(5)) inside
                0, 1:
                    put_byte(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
                2:
                begin
                    put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
                    if ($urandom_range(99) < 80)
                        put_byte(esc_letters[$urandom_range(10)], 1'b0, 1'b0, 1'b1);
                    else
                        put_byte(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
                end
                3:
                begin
                    put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
                    put_byte(($urandom_range(1) == 1) ? CH_LOWER_X : CH_UPPER_X,
                             1'b0, 1'b0, 1'b1);
                    repeat ($urandom_range(4))
                    begin
                        r = $urandom_range(21);
                        if (r < 10)
                            put_byte(CH_ZERO + 8'(r), 1'b0, 1'b0, 1'b1);
                        else if (r < 16)
                            put_byte(CH_LOWER_A + 8'(r - 10), 1'b0, 1'b0, 1'b1);
                        else
                            put_byte(CH_UPPER_A + 8'(r - 16), 1'b0, 1'b0, 1'b1);
                    end
                end
                4:
                begin
                    put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
                    repeat ($urandom_range(4, 1))
                        put_byte(CH_ZERO + 8'($urandom_range(7)), 1'b0, 1'b0, 1'b1);
                end
                default:
                begin
                    put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
                    put_byte(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
                end
            endcase
        end
    endtask

    // Mostly well-formed tokens with random content; the rest is stray bytes, one-byte
    // tokens, bad quotes, dangling escapes and tokens cut off by the next one.
    task automatic push_token();
        int kind;
        begin
            kind = $urandom_range(99);
            if (kind < 6) begin
                repeat ($urandom_range(3, 1))
                    put_byte(8'($urandom_range(255)), 1'b0, $urandom_range(1) == 1, 1'b0);
            end
            else if (kind < 10) begin
                put_byte(8'($urandom_range(255)), 1'b1, 1'b1, 1'b1);
            end
            else
            begin
                put_byte(($urandom_range(99) < 8) ? 8'($urandom_range(255)) : CH_QUOTE,
                         1'b1, 1'b0, 1'b1);
                repeat ($urandom_range(6))
                    push_piece();
                if ($urandom_range(99) >= 8) begin
                    if ($urandom_range(99) < 10)
                        put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
                    put_byte(($urandom_range(99) < 88) ? CH_QUOTE : 8'($urandom_range(255)),
                             1'b0, 1'b1, 1'b1);
                end
            end
        end
    endtask

    task automatic push_random(input int count);
        int target;
        begin
            target = items_made + count;
            while (items_made < target)
                push_token();
        end
    endtask

    task automatic drain();
        begin
            do
                @(negedge clk);
            while (raw_bytes.size() != 0 || tok_valid || decoded_q.size() != 0);
            repeat (8) @(negedge clk);
        end
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_idle_pct = 20;
        recv_idle_pct = 62;
        phase = 1;

        // Extreme bytes, letter, hex and octal escapes, then an unknown letter.
        put_byte(CH_QUOTE, 1'b1, 1'b0, 1'b1);
        put_byte(8'h00, 1'b0, 1'b0, 1'b1);
        put_byte(8'hFF, 1'b0, 1'b0, 1'b1);
        put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
        put_byte(CH_LOWER_N, 1'b0, 1'b0, 1'b1);
        put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
        put_byte(CH_UPPER_X, 1'b0, 1'b0, 1'b1);
        put_byte(CH_ZERO + 8'd1, 1'b0, 1'b0, 1'b1);
        put_byte(CH_UPPER_F, 1'b0, 1'b0, 1'b1);
        put_byte(8'h7A, 1'b0, 1'b0, 1'b1);
        put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
        put_byte(CH_SEVEN, 1'b0, 1'b0, 1'b1);
        put_byte(CH_SEVEN, 1'b0, 1'b0, 1'b1);
        put_byte(CH_SEVEN, 1'b0, 1'b0, 1'b1);
        put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
        put_byte(8'h71, 1'b0, 1'b0, 1'b1);
        // A hex escape with no digit still pending at the closing quote.
        put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
        put_byte(CH_LOWER_X, 1'b0, 1'b0, 1'b1);
        put_byte(CH_QUOTE, 1'b0, 1'b1, 1'b1);
        // Stray byte, one-byte token, bad opening quote, backslash before the close.
        put_byte(CH_UPPER_A, 1'b0, 1'b0, 1'b0);
        put_byte(CH_APOS, 1'b1, 1'b1, 1'b1);
        put_byte(CH_UPPER_A, 1'b1, 1'b0, 1'b1);
        put_byte(CH_QUOTE, 1'b0, 1'b1, 1'b1);
        put_byte(CH_QUOTE, 1'b1, 1'b0, 1'b1);
        put_byte(CH_BACKSLASH, 1'b0, 1'b0, 1'b1);
        put_byte(CH_QUOTE, 1'b0, 1'b1, 1'b1);

        push_random(180);
        drain();

        send_idle_pct = 62;
        recv_idle_pct = 20;
        phase = 2;
        push_random(180);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase = 3;
        push_random(190);
        drain();

        if (fail_count == 0)
            $display("** string_escape_decoder_top: PASSED **");
        else
            $display("** string_escape_decoder_top: FAILED **");
        $finish;
    end

endmodule
